// ===== rtl/random_probe_entry_lock_table_unit_macros.svh =====
// Assertion macros for the random probe lock table unit.
`ifndef RANDOM_PROBE_ENTRY_LOCK_TABLE_UNIT_MACROS_SVH
`define RANDOM_PROBE_ENTRY_LOCK_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RPELT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RPELT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rpelt_pkg.sv =====
// Types and constants shared by the random probe lock table unit.
package rpelt_pkg;

  localparam int unsigned ADDR_BITS = 16;

  localparam logic [63:0] SEED_MUL  = 64'h27BB_2EE6_87B0_B0FD;
  localparam logic [63:0] SEED_ADD  = 64'h0000_0000_B504_F32D;
  localparam logic [63:0] SEED_INIT = 64'h0000_0000_0000_BEEF;

  typedef enum logic [1:0] {
    KIND_GET_VALID = 2'd0,
    KIND_GET_EMPTY = 2'd1,
    KIND_PUT_VALID = 2'd2,
    KIND_PUT_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_QUEUE_SIZE  = 3'd0,
    REG_PAGE_SIZE   = 3'd1,
    REG_LCG_MODULUS = 3'd2,
    REG_LCG_MULT    = 3'd3,
    REG_LCG_INCR    = 3'd4,
    REG_METRIC_MODE = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED0,
    ST_SEED1,
    ST_SEED2,
    ST_SEED3,
    ST_FSTART,
    ST_FWAIT,
    ST_IDX,
    ST_IDXW,
    ST_RD,
    ST_CHK,
    ST_MUL,
    ST_ADD,
    ST_STEPW,
    ST_PSTART,
    ST_PWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic        use_tag;
    logic [31:0] tag_mask;
    logic [39:0] entry_offset;
    logic [7:0]  entry_pattern;
    logic [31:0] entry_tag;
    logic [31:0] entry_touch;
    logic [63:0] entry_payload;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  slot_index;
    logic [39:0] out_offset;
    logic [7:0]  out_pattern;
    logic [31:0] out_tag;
    logic [31:0] out_touch;
    logic [63:0] out_payload;
  } out_t;

  typedef struct packed {
    logic        lock;
    logic [39:0] offset;
    logic [7:0]  pattern;
    logic [31:0] tag;
    logic [31:0] touch;
    logic [63:0] payload;
  } ent_t;

  typedef struct packed {
    logic [10:0] queue_size;
    logic [32:0] page_size;
    logic [11:0] lcg_modulus;
    logic [10:0] lcg_mult;
    logic [10:0] lcg_incr;
    logic        metric_mode;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [6:0]  nbits;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [32:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    ent_t                 wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/rpelt_mem.sv =====
// Entry memory: one write port, one read port with registered data.
module rpelt_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  rpelt_pkg::mem_req_t req,
  output rpelt_pkg::ent_t    rdata
);
  import rpelt_pkg::*;

  ent_t mem_r [DEPTH];
  ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rpelt_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend left aligned.
module rpelt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rpelt_pkg::div_req_t req,
  output rpelt_pkg::div_rsp_t rsp
);
  import rpelt_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [32:0] rem_r;
  logic [63:0] dvd_r;
  logic [63:0] quot_r;
  logic [32:0] dsr_r;

  logic [33:0] trial;
  logic        qbit;
  logic [32:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[63]};
  assign qbit    = trial >= {1'b0, dsr_r};
  assign rem_nxt = qbit ? 33'(trial - {1'b0, dsr_r}) : trial[32:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      dvd_r  <= req.dividend;
      dsr_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[62:0], 1'b0};
      quot_r <= {quot_r[62:0], qbit};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/rpelt_cfg.sv =====
// Configuration register file behind the APB-style port.
module rpelt_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [5:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output rpelt_pkg::cfg_t cfg
);
  import rpelt_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_e sel;

  assign wr_en = psel && penable && pwrite;
  assign sel   = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.queue_size  <= 11'd0;
      cfg_r.page_size   <= 33'd1048576;
      cfg_r.lcg_modulus <= 12'd1;
      cfg_r.lcg_mult    <= 11'd1;
      cfg_r.lcg_incr    <= 11'd1;
      cfg_r.metric_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (sel)
        REG_QUEUE_SIZE:  cfg_r.queue_size  <= pwdata[10:0];
        REG_PAGE_SIZE:   cfg_r.page_size   <= pwdata[32:0];
        REG_LCG_MODULUS: cfg_r.lcg_modulus <= pwdata[11:0];
        REG_LCG_MULT:    cfg_r.lcg_mult    <= pwdata[10:0];
        REG_LCG_INCR:    cfg_r.lcg_incr    <= pwdata[10:0];
        REG_METRIC_MODE: cfg_r.metric_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_QUEUE_SIZE:  prdata = 64'(cfg_r.queue_size);
      REG_PAGE_SIZE:   prdata = 64'(cfg_r.page_size);
      REG_LCG_MODULUS: prdata = 64'(cfg_r.lcg_modulus);
      REG_LCG_MULT:    prdata = 64'(cfg_r.lcg_mult);
      REG_LCG_INCR:    prdata = 64'(cfg_r.lcg_incr);
      REG_METRIC_MODE: prdata = 64'(cfg_r.metric_mode);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/random_probe_entry_lock_table_unit.sv =====
// Put: a start, a divide of the offset by the page size, then the result.
// Get: a seed step and start-index divide, then per probe an index, read and check (with the
// index divide when an out-of-range step needs it), a probe-order step (24-bit divide by the
// modulus) before each further probe, and the result after the last check.
// One item at a time, on a shared divider; a result held by out_stall keeps the next item in the done state.
// Reset: a clearing pass writes every entry zero and locked; inputs stall.
`include "random_probe_entry_lock_table_unit_macros.svh"

module random_probe_entry_lock_table_unit #(
  parameter int ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpelt_pkg::in_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpelt_pkg::out_t    out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [5:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);
  import rpelt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  mem_req_t mem_req;
  ent_t     rd;

  state_e state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          out_valid_r;
  out_t          out_r;
  out_t          res_r;
  in_t           req_r;
  logic [63:0]   seed_r;
  logic [63:0]   acc_r;
  logic [63:0]   prod_r;
  logic [10:0]   first_r;
  logic [11:0]   next_r;
  logic [10:0]   i_r;
  logic [11:0]   k_r;
  logic [10:0]   idx_r;

  logic [10:0] q_w;
  logic [11:0] m_w;
  logic [12:0] sum_w;
  logic        next_lt_q;
  logic        want_valid;
  logic        hit;
  logic        reject;
  logic        put_in_rng;
  logic        clr_last;
  logic        out_free;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [23:0] step_val;

  rpelt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  rpelt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rpelt_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rd)
  );

  assign cfg_pready = 1'b1;

  assign q_w = ({21'd0, cfg.queue_size} > 32'(ENTRIES)) ? 11'(ENTRIES) : cfg.queue_size;
  assign m_w = (cfg.lcg_modulus == 12'd0) ? 12'd1 : cfg.lcg_modulus;

  assign sum_w      = 13'(next_r) + 13'(first_r);
  assign next_lt_q  = next_r < 12'(q_w);
  assign want_valid = req_r.kind == KIND_GET_VALID;
  assign hit        = ((rd.pattern != 8'd0) == want_valid) &&
                      (!req_r.use_tag || ((rd.tag & req_r.tag_mask) != 32'd0)) &&
                      !rd.lock;
  assign reject     = (div_rsp.rem[11:0] >= 12'(q_w)) && (k_r < m_w);
  assign put_in_rng = div_rsp.quot < 64'(q_w);
  assign clr_last   = clr_cnt_r == AW'(ENTRIES - 1);
  assign out_free   = !out_valid_r || !out_stall;
  assign step_val   = prod_r[23:0] + 24'(cfg.lcg_incr);

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_GET_VALID || in_data.kind == KIND_GET_EMPTY) begin
            state_nxt = (q_w == 11'd0) ? ST_DONE : ST_SEED0;
          end else if (cfg.page_size == 33'd0 ||
                       (in_data.kind == KIND_PUT_VALID && in_data.entry_pattern == 8'd0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_PSTART;
          end
        end
      end
      ST_SEED0:  state_nxt = ST_SEED1;
      ST_SEED1:  state_nxt = ST_SEED2;
      ST_SEED2:  state_nxt = ST_SEED3;
      ST_SEED3:  state_nxt = ST_FSTART;
      ST_FSTART: state_nxt = ST_FWAIT;
      ST_FWAIT:  if (div_rsp.done) state_nxt = ST_IDX;
      ST_IDX:    state_nxt = next_lt_q ? ST_RD : ST_IDXW;
      ST_IDXW:   if (div_rsp.done) state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_CHK;
      ST_CHK: begin
        if (hit || i_r == q_w - 11'd1) state_nxt = ST_DONE;
        else state_nxt = ST_MUL;
      end
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_STEPW;
      ST_STEPW:  if (div_rsp.done) state_nxt = reject ? ST_MUL : ST_IDX;
      ST_PSTART: state_nxt = ST_PWAIT;
      ST_PWAIT:  if (div_rsp.done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory, divider and multiplier controls
  always_comb begin
    mem_req = '0;
    div_req = '0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = ADDR_BITS'(clr_cnt_r);
        mem_req.wdata.lock = 1'b1;
      end
      ST_SEED0: begin
        mul_a = seed_r[31:0];
        mul_b = SEED_MUL[31:0];
      end
      ST_SEED1: begin
        mul_a = seed_r[63:32];
        mul_b = SEED_MUL[31:0];
      end
      ST_SEED2: begin
        mul_a = seed_r[31:0];
        mul_b = SEED_MUL[63:32];
      end
      ST_FSTART: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 7'd64;
        div_req.dividend = seed_r;
        div_req.divisor  = 33'(q_w);
      end
      ST_IDX: begin
        if (!next_lt_q) begin
          div_req.start    = 1'b1;
          div_req.nbits    = 7'd13;
          div_req.dividend = {sum_w, 51'd0};
          div_req.divisor  = 33'(q_w);
        end
      end
      ST_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ADDR_BITS'(idx_r);
      end
      ST_CHK: begin
        if (hit) begin
          mem_req.we         = 1'b1;
          mem_req.waddr      = ADDR_BITS'(idx_r);
          mem_req.wdata      = rd;
          mem_req.wdata.lock = 1'b1;
        end
      end
      ST_MUL: begin
        mul_a = 32'(cfg.lcg_mult);
        mul_b = 32'(next_r);
      end
      ST_ADD: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 7'd24;
        div_req.dividend = {step_val, 40'd0};
        div_req.divisor  = 33'(m_w);
      end
      ST_PSTART: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 7'd40;
        div_req.dividend = {req_r.entry_offset, 24'd0};
        div_req.divisor  = cfg.page_size;
      end
      ST_PWAIT: begin
        if (div_rsp.done && put_in_rng) begin
          mem_req.we            = 1'b1;
          mem_req.waddr         = ADDR_BITS'(div_rsp.quot);
          mem_req.wdata.lock    = 1'b0;
          mem_req.wdata.offset  = req_r.entry_offset;
          mem_req.wdata.pattern = (req_r.kind == KIND_PUT_VALID) ? req_r.entry_pattern
                                                                 : 8'd0;
          mem_req.wdata.tag     = req_r.entry_tag;
          mem_req.wdata.touch   = req_r.entry_touch;
          mem_req.wdata.payload = req_r.entry_payload;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= SEED_INIT;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_SEED3) seed_r <= {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_r <= in_data;
          res_r <= '0;
        end
      end
      ST_SEED1: acc_r <= prod_r + SEED_ADD;
      ST_SEED2: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
      ST_FWAIT: begin
        if (div_rsp.done) begin
          first_r <= div_rsp.rem[10:0];
          next_r  <= 12'd1;
          i_r     <= '0;
        end
      end
      ST_IDX: begin
        if (next_lt_q) begin
          idx_r <= (sum_w >= 13'(q_w)) ? 11'(sum_w - 13'(q_w)) : sum_w[10:0];
        end
      end
      ST_IDXW: if (div_rsp.done) idx_r <= div_rsp.rem[10:0];
      ST_CHK: begin
        if (hit) begin
          res_r.ok          <= 1'b1;
          res_r.slot_index  <= idx_r[9:0];
          res_r.out_offset  <= rd.offset;
          res_r.out_pattern <= rd.pattern;
          res_r.out_tag     <= rd.tag;
          res_r.out_payload <= rd.payload;
          if (!want_valid) res_r.out_touch <= rd.touch;
          else if (cfg.metric_mode) res_r.out_touch <= 32'(i_r);
          else res_r.out_touch <= rd.touch + 32'd1;
        end else begin
          i_r <= i_r + 11'd1;
          k_r <= '0;
        end
      end
      ST_STEPW: begin
        if (div_rsp.done) begin
          next_r <= div_rsp.rem[11:0];
          if (reject) k_r <= k_r + 12'd1;
        end
      end
      ST_PWAIT: begin
        if (div_rsp.done && put_in_rng) begin
          res_r.ok         <= 1'b1;
          res_r.slot_index <= div_rsp.quot[9:0];
        end
      end
      ST_DONE: if (out_free) out_r <= res_r;
      default: ;
    endcase
  end

  `RPELT_IMPLY(a_clear_stalls, state_r == ST_CLEAR, in_stall, "input taken during clear")
  `RPELT_IMPLY(a_idle_div_quiet, state_r == ST_IDLE, !div_rsp.busy, "divider busy while idle")
  `RPELT_IMPLY(a_write_source, mem_req.we, state_r == ST_CLEAR || state_r == ST_CHK || state_r == ST_PWAIT, "unexpected memory write")
  `RPELT_NEXT(a_hit_finishes, state_r == ST_CHK && hit, state_r == ST_DONE, "hit did not finish the get")

endmodule
